/* rtl/mbs_pkg.sv */
`default_nettype none

package mbs_pkg;

    // default cube edge limit
    localparam int DEF_MAX_GRID = 16;

    // payload field widths
    localparam int COORD_W = 4;
    localparam int RAND_W  = 16;
    localparam int FACE_W  = 14;
    localparam int GRID_W  = 5;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [GRID_W-1:0] GRID_RESET = 5'd16;

    // opcodes
    localparam logic OP_START = 1'b0;

    // result status codes
    localparam logic [1:0] ST_START  = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_BACK   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_z;
        logic [RAND_W-1:0]  random_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FACE_W-1:0]  face_index;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
    } out_word_t;

endpackage

`default_nettype wire

/* rtl/mbs_ram.sv */
`default_nettype none

module mbs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/maze_backtracker_step.sv */
`default_nettype none

// channel   | direction | handshake              | word
// ----------+-----------+------------------------+-------------------------------
// s_        | in        | s_valid / s_ready      | in_word_t: opcode, start, random
// m_        | out       | m_valid / m_ready      | out_word_t: status, face, cell
// apb       | in/out    | psel, penable, pready  | grid_size at byte address 0
//
// per word: start sweeps the whole visited map, then marks the start cell; a step reads
//   the top cell and probes its six neighbours through the one read port of the visited
//   map, then backtracks if none is free, else runs the 2-bit-per-cycle remainder loop
//   and the horner steps to open a face; a finished report goes straight out
// one word at a time: s_ready is high only while the sequencer is idle
// the result waits in an output register, so a new word is taken while it stalls
// reset (aresetn low, synchronous) empties the stack and sets grid_size to 16;
//   the visited map is left as is and is swept by every start word

module maze_backtracker_step import mbs_pkg::*; #(
    parameter int MAX_GRID = DEF_MAX_GRID
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_word_t            s_data,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_word_t                m_data,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    // geometry derived from the cube limit
    localparam int CW        = $clog2(MAX_GRID);      // stored coordinate
    localparam int GW        = $clog2(MAX_GRID + 1);  // effective edge length
    localparam int NW        = CW + 1;                // neighbour coordinate, may overflow
    localparam int AW        = CW + 2;                // plane code plus depth
    localparam int CELL_W    = 3 * CW;                // packed {z,y,x} cell address
    localparam int CELLS     = MAX_GRID ** 3;
    localparam int SAW       = $clog2(CELLS);
    localparam int CNTW      = $clog2(CELLS + 1);
    localparam int MOD_STEPS = RAND_W / 2;
    localparam int MODW      = $clog2(MOD_STEPS);

    // sequencer states
    localparam logic [3:0] FSM_IDLE   = 4'd0;
    localparam logic [3:0] FSM_CLEAR  = 4'd1;
    localparam logic [3:0] FSM_TOP    = 4'd2;
    localparam logic [3:0] FSM_TOPW   = 4'd3;
    localparam logic [3:0] FSM_PROBE  = 4'd4;
    localparam logic [3:0] FSM_DECIDE = 4'd5;
    localparam logic [3:0] FSM_MOD    = 4'd6;
    localparam logic [3:0] FSM_PICK   = 4'd7;
    localparam logic [3:0] FSM_MAC    = 4'd8;
    localparam logic [3:0] FSM_MARK   = 4'd9;
    localparam logic [3:0] FSM_OUT    = 4'd10;

    // neighbour axes and face plane codes
    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] PLANE_XY = 2'd0;
    localparam logic [1:0] PLANE_XZ = 2'd1;
    localparam logic [1:0] PLANE_YZ = 2'd2;
    localparam logic [2:0] DIR_END  = 3'd6;

    // horner steps of the face index
    localparam logic [1:0] MAC_DEPTH = 2'd0;
    localparam logic [1:0] MAC_ROW   = 2'd1;
    localparam logic [1:0] MAC_COL   = 2'd2;

    localparam logic REG_GRID_SIZE = 1'b0;

    // registers
    logic [3:0]         state_reg,    state_next;
    logic [GRID_W-1:0]  grid_reg,     grid_next;
    logic [CNTW-1:0]    count_reg,    count_next;
    logic               m_valid_reg,  m_valid_next;
    out_word_t          m_data_reg,   m_data_next;
    out_word_t          res_reg,      res_next;
    logic [CW-1:0]      tx_reg,       tx_next;
    logic [CW-1:0]      ty_reg,       ty_next;
    logic [CW-1:0]      tz_reg,       tz_next;
    logic [CW-1:0]      nx_reg,       nx_next;
    logic [CW-1:0]      ny_reg,       ny_next;
    logic [CW-1:0]      nz_reg,       nz_next;
    logic [CELL_W-1:0]  clear_reg,    clear_next;
    logic [2:0]         dir_cnt_reg,  dir_cnt_next;
    logic [2:0]         probe_d_reg,  probe_d_next;
    logic               probe_live_reg, probe_live_next;
    logic [5:0]         mask_reg,     mask_next;
    logic [RAND_W-1:0]  rnd_reg,      rnd_next;
    logic [2:0]         rem_reg,      rem_next;
    logic [2:0]         n_reg,        n_next;
    logic [MODW-1:0]    mod_cnt_reg,  mod_cnt_next;
    logic [FACE_W-1:0]  acc_reg,      acc_next;
    logic [1:0]         mac_step_reg, mac_step_next;
    logic [AW-1:0]      dd_reg,       dd_next;
    logic [CW-1:0]      fx_reg,       fx_next;
    logic [CW-1:0]      fy_reg,       fy_next;

    // effective edge length and configuration
    logic [GW-1:0]      g;
    logic [GW-1:0]      g_m1;
    logic               cfg_wr;

    // neighbour generator, shared by probing and picking
    logic [2:0]         nb_d;
    logic [NW-1:0]      nb_x, nb_y, nb_z;
    logic               nb_ok;
    logic [CELL_W-1:0]  nb_addr;

    // pick, face operands, remainder and horner unit
    logic [2:0]         pick_d;
    logic [2:0]         seen;
    logic [1:0]         f_plane;
    logic [CW-1:0]      f_a, f_b, f_depth;
    logic [AW-1:0]      f_dd;
    logic [3:0]         r1, r2;
    logic [AW-1:0]      mac_add;
    logic [FACE_W-1:0]  mac_sum;
    logic [CNTW-1:0]    top_idx;
    logic [CW-1:0]      sx, sy, sz;

    // memories
    logic               vis_wr_en, vis_wr_data, vis_rd_en, vis_rd_data;
    logic [CELL_W-1:0]  vis_wr_addr, vis_rd_addr;
    logic               stk_wr_en, stk_rd_en;
    logic [SAW-1:0]     stk_wr_addr, stk_rd_addr;
    logic [CELL_W-1:0]  stk_rd_data, mark_addr;

    function automatic logic [CW-1:0] sat_coord(input logic [COORD_W-1:0] v,
                                                input logic [GW-1:0] lim);
        if (32'(v) > 32'(lim)) begin
            return CW'(lim);
        end
        return CW'(v);
    endfunction

    // grid size 0 acts as 1, anything above the limit as the limit
    always_comb begin
        if (grid_reg == '0) begin
            g = GW'(1);
        end else if (32'(grid_reg) > MAX_GRID) begin
            g = GW'(MAX_GRID);
        end else begin
            g = GW'(grid_reg);
        end
        g_m1 = g - GW'(1);
    end

    assign sx = sat_coord(s_data.start_x, g_m1);
    assign sy = sat_coord(s_data.start_y, g_m1);
    assign sz = sat_coord(s_data.start_z, g_m1);

    // apb register file: one register, always ready
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_GRID_SIZE);
    assign prdata  = (paddr[2] == REG_GRID_SIZE) ? PDATA_W'(grid_reg) : '0;

    // neighbour of the top cell in direction nb_d (+x,-x,+y,-y,+z,-z)
    always_comb begin
        nb_d  = (state_reg == FSM_PICK) ? pick_d : dir_cnt_reg;
        nb_x  = NW'(tx_reg);
        nb_y  = NW'(ty_reg);
        nb_z  = NW'(tz_reg);
        nb_ok = 1'b1;
        case (nb_d[2:1])
            AXIS_X: begin
                if (nb_d[0]) begin
                    nb_ok = (tx_reg != '0);
                    nb_x  = nb_x - NW'(1);
                end else begin
                    nb_x  = nb_x + NW'(1);
                end
            end
            AXIS_Y: begin
                if (nb_d[0]) begin
                    nb_ok = (ty_reg != '0);
                    nb_y  = nb_y - NW'(1);
                end else begin
                    nb_y  = nb_y + NW'(1);
                end
            end
            AXIS_Z: begin
                if (nb_d[0]) begin
                    nb_ok = (tz_reg != '0);
                    nb_z  = nb_z - NW'(1);
                end else begin
                    nb_z  = nb_z + NW'(1);
                end
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
        // bounds follow the current grid size, even for a top cell left outside it
        if (nb_x >= NW'(g) || nb_y >= NW'(g) || nb_z >= NW'(g)) begin
            nb_ok = 1'b0;
        end
        nb_addr = {nb_z[CW-1:0], nb_y[CW-1:0], nb_x[CW-1:0]};
    end

    // rem_reg-th candidate in direction order
    always_comb begin
        pick_d = '0;
        seen   = '0;
        for (int i = 0; i < 6; i++) begin
            if (mask_reg[i]) begin
                if (seen == rem_reg) begin
                    pick_d = 3'(i);
                end
                seen = seen + 3'd1;
            end
        end
    end

    // face operands: plane code, in-plane coordinates, depth slice
    always_comb begin
        case (pick_d[2:1])
            AXIS_X: begin
                f_plane = PLANE_YZ;
                f_a     = ty_reg;
                f_b     = tz_reg;
                f_depth = tx_reg;
            end
            AXIS_Y: begin
                f_plane = PLANE_XZ;
                f_a     = tx_reg;
                f_b     = tz_reg;
                f_depth = ty_reg;
            end
            default: begin
                f_plane = PLANE_XY;
                f_a     = tx_reg;
                f_b     = ty_reg;
                f_depth = tz_reg;
            end
        endcase
        // plane*(g+1) + depth = plane*g + (plane + depth), depth one up on a positive step
        f_dd = AW'(f_depth) + AW'(!pick_d[0]) + AW'(f_plane);
    end

    // restoring remainder, two bits of the random word a cycle
    always_comb begin
        r1 = {rem_reg, rnd_reg[RAND_W-1]};
        if (r1 >= {1'b0, n_reg}) begin
            r1 = r1 - {1'b0, n_reg};
        end
        r2 = {r1[2:0], rnd_reg[RAND_W-2]};
        if (r2 >= {1'b0, n_reg}) begin
            r2 = r2 - {1'b0, n_reg};
        end
    end

    // shared multiply-add: acc*g + addend, kept to the face field width
    always_comb begin
        case (mac_step_reg)
            MAC_DEPTH: mac_add = dd_reg;
            MAC_ROW:   mac_add = AW'(fy_reg);
            default:   mac_add = AW'(fx_reg);
        endcase
        mac_sum = acc_reg * FACE_W'(g) + FACE_W'(mac_add);
    end

    assign top_idx   = count_reg - CNTW'(1);
    assign mark_addr = {nz_reg, ny_reg, nx_reg};

    // memory ports
    always_comb begin
        vis_wr_en   = (state_reg == FSM_CLEAR) || (state_reg == FSM_MARK);
        vis_wr_addr = (state_reg == FSM_CLEAR) ? clear_reg : mark_addr;
        vis_wr_data = (state_reg == FSM_MARK);
        vis_rd_en   = (state_reg == FSM_PROBE) && (dir_cnt_reg != DIR_END) && nb_ok;
        vis_rd_addr = nb_addr;
        stk_wr_en   = (state_reg == FSM_MARK) && (count_reg < CNTW'(CELLS));
        stk_wr_addr = count_reg[SAW-1:0];
        stk_rd_en   = (state_reg == FSM_TOP);
        stk_rd_addr = top_idx[SAW-1:0];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        grid_next       = cfg_wr ? pwdata[GRID_W-1:0] : grid_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        res_next        = res_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        tz_next         = tz_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        nz_next         = nz_reg;
        clear_next      = clear_reg;
        dir_cnt_next    = dir_cnt_reg;
        probe_d_next    = probe_d_reg;
        probe_live_next = probe_live_reg;
        mask_next       = mask_reg;
        rnd_next        = rnd_reg;
        rem_next        = rem_reg;
        n_next          = n_reg;
        mod_cnt_next    = mod_cnt_reg;
        acc_next        = acc_reg;
        mac_step_next   = mac_step_reg;
        dd_next         = dd_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;

        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    if (s_data.opcode == OP_START) begin
                        nx_next    = sx;
                        ny_next    = sy;
                        nz_next    = sz;
                        count_next = '0;
                        clear_next = '0;
                        res_next   = '{status: ST_START, face_index: '0,
                                       cell_x: COORD_W'(sx), cell_y: COORD_W'(sy),
                                       cell_z: COORD_W'(sz)};
                        state_next = FSM_CLEAR;
                    end else if (count_reg == '0) begin
                        res_next   = '{status: ST_FINISH, face_index: '0,
                                       cell_x: '0, cell_y: '0, cell_z: '0};
                        state_next = FSM_OUT;
                    end else begin
                        rnd_next   = s_data.random_value;
                        state_next = FSM_TOP;
                    end
                end
            end
            FSM_CLEAR: begin
                clear_next = clear_reg + CELL_W'(1);
                if (clear_reg == '1) begin
                    state_next = FSM_MARK;
                end
            end
            FSM_TOP: begin
                state_next = FSM_TOPW;
            end
            FSM_TOPW: begin
                tx_next         = stk_rd_data[CW-1:0];
                ty_next         = stk_rd_data[2*CW-1:CW];
                tz_next         = stk_rd_data[3*CW-1:2*CW];
                dir_cnt_next    = '0;
                probe_live_next = 1'b0;
                mask_next       = '0;
                state_next      = FSM_PROBE;
            end
            FSM_PROBE: begin
                // issue one probe, judge the one before
                if (probe_live_reg && !vis_rd_data) begin
                    mask_next[probe_d_reg] = 1'b1;
                end
                probe_d_next    = dir_cnt_reg;
                probe_live_next = vis_rd_en;
                dir_cnt_next    = dir_cnt_reg + 3'd1;
                if (dir_cnt_reg == DIR_END) begin
                    state_next = FSM_DECIDE;
                end
            end
            FSM_DECIDE: begin
                n_next       = 3'($countones(mask_reg));
                rem_next     = '0;
                mod_cnt_next = '0;
                if (mask_reg == '0) begin
                    count_next = top_idx;
                    res_next   = '{status: ST_BACK, face_index: '0,
                                   cell_x: COORD_W'(tx_reg), cell_y: COORD_W'(ty_reg),
                                   cell_z: COORD_W'(tz_reg)};
                    state_next = FSM_OUT;
                end else begin
                    state_next = FSM_MOD;
                end
            end
            FSM_MOD: begin
                rem_next     = r2[2:0];
                rnd_next     = rnd_reg << 2;
                mod_cnt_next = mod_cnt_reg + MODW'(1);
                if (mod_cnt_reg == MODW'(MOD_STEPS - 1)) begin
                    state_next = FSM_PICK;
                end
            end
            FSM_PICK: begin
                nx_next       = nb_x[CW-1:0];
                ny_next       = nb_y[CW-1:0];
                nz_next       = nb_z[CW-1:0];
                acc_next      = FACE_W'(f_plane);
                dd_next       = f_dd;
                fx_next       = f_a;
                fy_next       = f_b;
                mac_step_next = MAC_DEPTH;
                state_next    = FSM_MAC;
            end
            FSM_MAC: begin
                acc_next      = mac_sum;
                mac_step_next = mac_step_reg + 2'd1;
                if (mac_step_reg == MAC_COL) begin
                    res_next   = '{status: ST_OPEN, face_index: mac_sum,
                                   cell_x: COORD_W'(nx_reg), cell_y: COORD_W'(ny_reg),
                                   cell_z: COORD_W'(nz_reg)};
                    state_next = FSM_MARK;
                end
            end
            FSM_MARK: begin
                if (count_reg < CNTW'(CELLS)) begin
                    count_next = count_reg + CNTW'(1);
                end
                state_next = FSM_OUT;
            end
            FSM_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            grid_reg    <= GRID_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            grid_reg    <= grid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        m_data_reg     <= m_data_next;
        res_reg        <= res_next;
        tx_reg         <= tx_next;
        ty_reg         <= ty_next;
        tz_reg         <= tz_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        nz_reg         <= nz_next;
        clear_reg      <= clear_next;
        dir_cnt_reg    <= dir_cnt_next;
        probe_d_reg    <= probe_d_next;
        probe_live_reg <= probe_live_next;
        mask_reg       <= mask_next;
        rnd_reg        <= rnd_next;
        rem_reg        <= rem_next;
        n_reg          <= n_next;
        mod_cnt_reg    <= mod_cnt_next;
        acc_reg        <= acc_next;
        mac_step_reg   <= mac_step_next;
        dd_reg         <= dd_next;
        fx_reg         <= fx_next;
        fy_reg         <= fy_next;
    end

    assign s_ready = (state_reg == FSM_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // visited map, one bit per packed {z,y,x} address
    mbs_ram #(
        .WIDTH (1),
        .DEPTH (2 ** CELL_W)
    ) u_visited (
        .clk     (aclk),
        .wr_en   (vis_wr_en),
        .wr_addr (vis_wr_addr),
        .wr_data (vis_wr_data),
        .rd_en   (vis_rd_en),
        .rd_addr (vis_rd_addr),
        .rd_data (vis_rd_data)
    );

    // path stack of packed cell addresses
    mbs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_stack (
        .clk     (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (mark_addr),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

endmodule

`default_nettype wire

/* rtl/mbs_checker.sv */
`default_nettype none

module mbs_checker import mbs_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_word_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    // finished reports nothing
    a_finish_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FINISH) |->
            (m_data.face_index == '0) && (m_data.cell_x == '0) &&
            (m_data.cell_y == '0) && (m_data.cell_z == '0))
        else $error("finished word carries a cell or face");

    // only an opened face carries a face index
    a_face_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_data.status == ST_START) || (m_data.status == ST_BACK)) |->
            (m_data.face_index == '0))
        else $error("face index on a start or backtrack word");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind maze_backtracker_step mbs_checker u_mbs_checker (.*);

`default_nettype wire

/* tb/maze_backtracker_step_tb.sv */
module maze_backtracker_step_tb;
    import mbs_pkg::*;

    localparam int MG          = DEF_MAX_GRID;
    localparam int CELLS       = MG * MG * MG;
    localparam logic OP_STEP   = ~OP_START;
    localparam logic [PADDR_W-1:0] GRID_ADDR = '0;

    // rough cycle costs used only to size the watchdog
    localparam int START_COST  = CELLS + 16;
    localparam int STEP_COST   = 32;
    localparam int STALL_ALLOW = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;
    localparam int RAND_PHASES = 22;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_word_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_word_t            m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    maze_backtracker_step dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the carver state
    bit                 seen_cell [CELLS];
    int unsigned        trail [CELLS];
    int unsigned        trail_len = 0;
    logic [GRID_W-1:0]  grid_reg  = GRID_RESET;

    in_word_t   maze_cmds[$];      // words waiting to be offered
    in_word_t   batch[$];          // words of the phase being built
    out_word_t  carve_reports[$];  // predicted results, oldest first

    int  fault_count  = 0;
    int  report_count = 0;
    int  cycle_count  = 0;
    int  cycle_limit  = 20000;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  s_took       = 1'b0;

    always #1 aclk = ~aclk;

    // one carving step on the local state, returns the expected result word
    function automatic out_word_t carve_predict(in_word_t w);
        int unsigned g, sx, sy, sz, top, tx, ty, tz, n, pick, axis;
        int unsigned dirn, depth, fx, fy, face, nx, ny, nz, nc;
        int unsigned c [3];
        int unsigned cand [6];
        bit pos;
        out_word_t r;
        r = '0;
        // out-of-range sizes clamp to 1 .. MG
        g = (grid_reg == 0) ? 1 : ((grid_reg > MG) ? MG : grid_reg);
        if (w.opcode == OP_START) begin
            sx = (w.start_x > g - 1) ? g - 1 : w.start_x;
            sy = (w.start_y > g - 1) ? g - 1 : w.start_y;
            sz = (w.start_z > g - 1) ? g - 1 : w.start_z;
            foreach (seen_cell[i]) seen_cell[i] = 1'b0;
            nc = (sz * MG + sy) * MG + sx;
            seen_cell[nc] = 1'b1;
            trail[0] = nc;
            trail_len = 1;
            r.status = ST_START;
            r.cell_x = sx[COORD_W-1:0];
            r.cell_y = sy[COORD_W-1:0];
            r.cell_z = sz[COORD_W-1:0];
            return r;
        end
        // empty stack: maze done, nothing moves
        if (trail_len == 0) begin
            r.status = ST_FINISH;
            return r;
        end
        top = trail[trail_len - 1];
        tx = top % MG;
        ty = (top / MG) % MG;
        tz = (top / (MG * MG)) % MG;
        n = 0;
        for (int unsigned d = 0; d < 6; d++) begin
            axis = d >> 1;
            c[0] = tx;
            c[1] = ty;
            c[2] = tz;
            if ((d & 1) != 0) begin
                if (c[axis] == 0) continue;
                c[axis] = c[axis] - 1;
            end else begin
                c[axis] = c[axis] + 1;
            end
            if (c[0] >= g || c[1] >= g || c[2] >= g) continue;
            if (!seen_cell[(c[2] * MG + c[1]) * MG + c[0]]) begin
                cand[n] = d;
                n++;
            end
        end
        if (n == 0) begin
            trail_len--;
            r.status = ST_BACK;
            r.cell_x = tx[COORD_W-1:0];
            r.cell_y = ty[COORD_W-1:0];
            r.cell_z = tz[COORD_W-1:0];
            return r;
        end
        pick = cand[w.random_value % n];
        axis = pick >> 1;
        pos  = ((pick & 1) == 0);
        nx = tx;
        ny = ty;
        nz = tz;
        if (axis == 0) begin
            nx = pos ? tx + 1 : tx - 1;
            dirn = 2; fx = ty; fy = tz; depth = tx;
        end else if (axis == 1) begin
            ny = pos ? ty + 1 : ty - 1;
            dirn = 1; fx = tx; fy = tz; depth = ty;
        end else begin
            nz = pos ? tz + 1 : tz - 1;
            dirn = 0; fx = tx; fy = ty; depth = tz;
        end
        if (pos) depth = depth + 1;
        face = dirn * (g + 1) * g * g + depth * g * g + fy * g + fx;
        nc = (nz * MG + ny) * MG + nx;
        seen_cell[nc] = 1'b1;
        if (trail_len < CELLS) begin
            trail[trail_len] = nc;
            trail_len++;
        end
        r.status     = ST_OPEN;
        r.face_index = face[FACE_W-1:0];
        r.cell_x     = nx[COORD_W-1:0];
        r.cell_y     = ny[COORD_W-1:0];
        r.cell_z     = nz[COORD_W-1:0];
        return r;
    endfunction

    function automatic in_word_t start_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                            logic [COORD_W-1:0] z, logic [RAND_W-1:0] rv);
        in_word_t w;
        w.opcode       = OP_START;
        w.start_x      = x;
        w.start_y      = y;
        w.start_z      = z;
        w.random_value = rv;
        return w;
    endfunction

    // start fields are ignored by a step, so they carry noise
    function automatic in_word_t step_word(logic [RAND_W-1:0] rv);
        in_word_t w;
        w.opcode       = OP_STEP;
        w.start_x      = COORD_W'($urandom());
        w.start_y      = COORD_W'($urandom());
        w.start_z      = COORD_W'($urandom());
        w.random_value = rv;
        return w;
    endfunction

    task automatic note_fault(string msg);
        fault_count++;
        if (fault_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    // hand the built phase over to the sender and widen the watchdog
    task automatic launch_batch();
        foreach (batch[i]) begin
            cycle_limit += 4 * ((batch[i].opcode == OP_START ? START_COST : STEP_COST)
                                + STALL_ALLOW);
            maze_cmds.push_back(batch[i]);
        end
        cycle_limit += 200;
        batch.delete();
    endtask

    // every offered word answered and the block back at rest
    task automatic settle_idle();
        do @(posedge aclk);
        while (maze_cmds.size() != 0 || s_valid || carve_reports.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // write grid_size with noise in the unused bits, then read it back
    task automatic set_grid(logic [GRID_W-1:0] v);
        logic [PDATA_W-1:0] d;
        d = $urandom();
        d[GRID_W-1:0] = v;
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = GRID_ADDR; pwdata = d;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
        @(posedge aclk);
    endtask

    // sender: holds a word until taken, gaps at random
    always @(negedge aclk) begin
        if (!s_valid || s_took) begin
            if (maze_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_data  <= maze_cmds.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off while words are queued
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && maze_cmds.size() > 30 && report_count > 50) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: tracks config writes, predicts on each taken word, checks results
    always @(posedge aclk) begin
        out_word_t want;
        s_took <= s_valid && s_ready;
        if (aresetn) begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    grid_reg = pwdata[GRID_W-1:0];
                end else if (prdata !== PDATA_W'(grid_reg)) begin
                    note_fault($sformatf("grid_size read %0h, want %0h", prdata, grid_reg));
                end
            end
            if (s_valid && s_ready) carve_reports.push_back(carve_predict(s_data));
            if (m_valid && m_ready) begin
                report_count++;
                if (carve_reports.size() == 0) begin
                    note_fault($sformatf("unexpected result word %0h", m_data));
                end else begin
                    want = carve_reports.pop_front();
                    if (m_data.status !== want.status
                        || m_data.face_index !== want.face_index
                        || m_data.cell_x !== want.cell_x
                        || m_data.cell_y !== want.cell_y
                        || m_data.cell_z !== want.cell_z) begin
                        note_fault($sformatf(
                            "word %0d: got %0d/%0d (%0d,%0d,%0d) want %0d/%0d (%0d,%0d,%0d)",
                            report_count, m_data.status, m_data.face_index,
                            m_data.cell_x, m_data.cell_y, m_data.cell_z,
                            want.status, want.face_index,
                            want.cell_x, want.cell_y, want.cell_z));
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int n, pick;
        logic [GRID_W-1:0] gsel;
        tx_idle_pct = 29;
        rx_idle_pct = 82;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // empty stack reports finished, then a corner start at reset size
        batch.push_back(step_word(16'h0000));
        batch.push_back(start_word(4'd0, 4'd0, 4'd0, 16'h0000));
        batch.push_back(step_word(16'h0000));
        batch.push_back(step_word(16'hFFFF));
        launch_batch();

        // size zero acts as one: start clamps to the origin, backtrack, finished
        settle_idle();
        set_grid(5'd0);
        batch.push_back(start_word(4'd15, 4'd15, 4'd15, 16'hFFFF));
        batch.push_back(step_word(16'h1234));
        batch.push_back(step_word(16'hFFFF));
        launch_batch();

        // oversize acts as the full cube, far corner start
        settle_idle();
        set_grid(5'd31);
        batch.push_back(start_word(4'd15, 4'd15, 4'd15, 16'h0000));
        batch.push_back(step_word(16'hFFFF));
        batch.push_back(step_word(16'hAAAA));
        launch_batch();

        // shrink mid-search: top cell ends up outside, still opens inward
        settle_idle();
        set_grid(5'd4);
        batch.push_back(start_word(4'd3, 4'd1, 4'd1, 16'h5555));
        launch_batch();
        settle_idle();
        set_grid(5'd3);
        batch.push_back(step_word(16'h0000));
        batch.push_back(step_word(16'h0005));
        batch.push_back(step_word(16'hFFFF));
        launch_batch();

        // random phases, mostly small cubes so searches run to the end
        for (int k = 0; k < RAND_PHASES; k++) begin
            settle_idle();
            pick = $urandom_range(99);
            if (pick < 70)      gsel = GRID_W'($urandom_range(4, 2));
            else if (pick < 84) gsel = GRID_W'($urandom_range(16, 5));
            else if (pick < 92) gsel = GRID_W'($urandom_range(1, 0));
            else                gsel = GRID_W'($urandom_range(31, 17));
            if ($urandom_range(9) != 0) set_grid(gsel);
            if (k < 7) begin
                tx_idle_pct = 29;
                rx_idle_pct = 82;
            end else if (k < 14) begin
                tx_idle_pct = 82;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // a phase without a leading start carries on the old search
            if ($urandom_range(99) < 85)
                batch.push_back(start_word(COORD_W'($urandom()), COORD_W'($urandom()),
                                           COORD_W'($urandom()), RAND_W'($urandom())));
            n = $urandom_range(60, 40);
            repeat (n) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    batch.push_back(start_word(COORD_W'($urandom()), COORD_W'($urandom()),
                                               COORD_W'($urandom()), RAND_W'($urandom())));
                else if (pick < 13)
                    batch.push_back(step_word($urandom_range(1) ? 16'hFFFF : 16'h0000));
                else
                    batch.push_back(step_word(RAND_W'($urandom())));
            end
            launch_batch();
        end

        settle_idle();
        repeat (30) @(posedge aclk);
        if (fault_count == 0 && carve_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mbs_pkg.sv
rtl/mbs_ram.sv
rtl/maze_backtracker_step.sv
rtl/mbs_checker.sv
tb/maze_backtracker_step_tb.sv
